/* rtl/lpht_pkg.sv */
package lpht_pkg;

	localparam int KEY_W     = 32;
	localparam int HASH_W    = 32;
	localparam int DATA_W    = 32;
	localparam int LIMIT_W   = 9;
	localparam int KIND_W    = 2;
	localparam int HASH_STEPS = HASH_W / 2;

	localparam logic [LIMIT_W-1:0] LIMIT_RST = 9'd192;

	localparam logic [1:0] ACT_GET = 2'd0;
	localparam logic [1:0] ACT_SET = 2'd1;
	localparam logic [1:0] ACT_DEL = 2'd2;

	localparam logic [KIND_W-1:0] KIND_EMPTY = 2'd0;
	localparam logic [KIND_W-1:0] KIND_LIVE  = 2'd1;
	localparam logic [KIND_W-1:0] KIND_TOMB  = 2'd2;

	localparam logic [1:0] STAT_OK   = 2'd0;
	localparam logic [1:0] STAT_MISS = 2'd1;
	localparam logic [1:0] STAT_FULL = 2'd2;

	typedef struct packed {
		logic [1:0]        action;
		logic [KEY_W-1:0]  key_id;
		logic [HASH_W-1:0] key_hash;
		logic [DATA_W-1:0] value_in;
	} req_t;

	typedef struct packed {
		logic [1:0]        status;
		logic              new_key;
		logic [DATA_W-1:0] value_out;
	} rsp_t;

	// start-slot unit request
	typedef struct packed {
		logic              start;
		logic [HASH_W-1:0] hash;
	} hs_req_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_HASH,
		S_PROBE,
		S_FIN
	} state_t;

endpackage

/* rtl/linear_probe_hash_table.sv */
// channel   dir   handshake          payload
// in        in    in_valid/in_stall  in_data   (lpht_pkg::req_t)
// out       out   out_valid/out_stall out_data (lpht_pkg::rsp_t)
// cfg       in    cfg_valid/cfg_ready cfg_data (load_limit)
//
// Power-of-two CAPACITY: each item probes slots with one read of the slot
// memory per cycle; refused sets and unknown actions skip the probe.
// Other CAPACITY values first run the start-slot reduction.
// After reset a clearing pass marks every slot empty;
// input is stalled meanwhile, cfg writes are taken.
// A result held by out_stall does not block the next input transfer.
module linear_probe_hash_table #(
	parameter int CAPACITY   = 256,
	parameter int VALUE_BITS = 32
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_stall,
	input  lpht_pkg::req_t               in_data,
	output logic                         out_valid,
	input  logic                         out_stall,
	output lpht_pkg::rsp_t               out_data,
	input  logic                         cfg_valid,
	output logic                         cfg_ready,
	input  logic [lpht_pkg::LIMIT_W-1:0] cfg_data
);

	localparam int IW   = $clog2(CAPACITY);
	localparam int CW   = $clog2(CAPACITY + 1);
	localparam int KW   = lpht_pkg::KEY_W;
	localparam int EW   = lpht_pkg::KIND_W + KW + VALUE_BITS;
	localparam int CMPW = (CW + 1 > lpht_pkg::LIMIT_W) ? CW + 1 : lpht_pkg::LIMIT_W;
	localparam logic [IW-1:0] IDX_LAST = IW'(CAPACITY - 1);
	localparam logic [CW-1:0] CNT_CAP  = CW'(CAPACITY);
	localparam logic [CW-1:0] CNT_LAST = CW'(CAPACITY - 1);

	lpht_pkg::state_t state_q, state_d;
	lpht_pkg::req_t   req_q;
	lpht_pkg::rsp_t   out_data_q, rsp_c;
	lpht_pkg::hs_req_t hs_req;

	logic                         skip_q, skip_c, full_c, acc;
	logic [lpht_pkg::LIMIT_W-1:0] load_limit_q;
	logic [CW-1:0]                used_q;
	logic                         clr_q;
	logic [IW-1:0]                clr_idx_q;
	logic                         hs_done;
	logic [IW-1:0]                hs_idx;

	logic [IW-1:0]          rd_idx_q;
	logic [CW-1:0]          issued_q;
	logic [CW-1:0]          evald_q;
	logic                   rvalid_s1;
	logic [IW-1:0]          idx_s1;
	logic                   have_tomb_q;
	logic [IW-1:0]          tomb_q;
	logic                   found_q, ins_ok_q, ins_empty_q;
	logic [IW-1:0]          tgt_q;
	logic [VALUE_BITS-1:0]  hit_val_q;
	logic                   out_valid_q, out_free;

	logic                   rd_en;
	logic [EW-1:0]          rdata;
	logic [1:0]             r_kind;
	logic [KW-1:0]          r_key;
	logic [VALUE_BITS-1:0]  r_val;
	logic                   eval_c, is_empty, is_hit, tomb_new, last_c, stop_c;

	logic                   fin_wr_c, fin_inc_c;
	logic [1:0]             fin_kind_c;
	logic [VALUE_BITS-1:0]  fin_val_c;
	logic                   we;
	logic [IW-1:0]          waddr;
	logic [EW-1:0]          wdata;

	// ---------------- start slot and slot memory ----------------
	lpht_start #(.CAPACITY(CAPACITY)) u_start (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (hs_req),
		.done   (hs_done),
		.idx    (hs_idx)
	);

	lpht_ram #(.DEPTH(CAPACITY), .WIDTH(EW)) u_ram (
		.clk   (clk),
		.we    (we),
		.waddr (waddr),
		.wdata (wdata),
		.re    (rd_en),
		.raddr (rd_idx_q),
		.rdata (rdata)
	);

	assign r_kind = rdata[EW-1 -: lpht_pkg::KIND_W];
	assign r_key  = rdata[VALUE_BITS +: KW];
	assign r_val  = rdata[VALUE_BITS-1:0];

	// ---------------- probe evaluation ----------------
	always_comb begin
		eval_c   = (state_q == lpht_pkg::S_PROBE) && rvalid_s1;
		is_empty = eval_c && (r_kind == lpht_pkg::KIND_EMPTY);
		is_hit   = eval_c && (r_kind == lpht_pkg::KIND_LIVE) && (r_key == req_q.key_id);
		tomb_new = eval_c && (r_kind == lpht_pkg::KIND_TOMB) && !have_tomb_q;
		last_c   = eval_c && (evald_q == CNT_LAST);
		stop_c   = is_empty || is_hit || last_c;
	end

	always_comb begin
		full_c = (CMPW'(used_q) + CMPW'(1)) > CMPW'(load_limit_q);
		case (in_data.action)
			lpht_pkg::ACT_SET: skip_c = full_c;
			lpht_pkg::ACT_GET,
			lpht_pkg::ACT_DEL: skip_c = 1'b0;
			default:           skip_c = 1'b1;
		endcase
	end

	// ---------------- next state ----------------
	always_comb begin
		state_d = state_q;
		case (state_q)
			lpht_pkg::S_IDLE: begin
				if (acc) begin
					if (skip_c) begin
						state_d = lpht_pkg::S_FIN;
					end else if (hs_done) begin
						state_d = lpht_pkg::S_PROBE;
					end else begin
						state_d = lpht_pkg::S_HASH;
					end
				end
			end
			lpht_pkg::S_HASH: begin
				if (hs_done) begin
					state_d = lpht_pkg::S_PROBE;
				end
			end
			lpht_pkg::S_PROBE: begin
				if (stop_c) begin
					state_d = lpht_pkg::S_FIN;
				end
			end
			lpht_pkg::S_FIN: begin
				if (out_free) begin
					state_d = lpht_pkg::S_IDLE;
				end
			end
			default: state_d = lpht_pkg::S_IDLE;
		endcase
	end

	// ---------------- outputs of the controller ----------------
	always_comb begin
		in_stall     = !((state_q == lpht_pkg::S_IDLE) && !clr_q);
		acc          = in_valid && !in_stall;
		hs_req.start = acc && !skip_c;
		hs_req.hash  = in_data.key_hash;
		rd_en        = (state_q == lpht_pkg::S_PROBE) && (issued_q != CNT_CAP) && !stop_c;
		out_free     = !out_valid_q || !out_stall;

		rsp_c.status    = lpht_pkg::STAT_MISS;
		rsp_c.new_key   = 1'b0;
		rsp_c.value_out = '0;
		fin_wr_c        = 1'b0;
		fin_inc_c       = 1'b0;
		fin_kind_c      = lpht_pkg::KIND_LIVE;
		fin_val_c       = VALUE_BITS'(req_q.value_in);

		case (req_q.action)
			lpht_pkg::ACT_GET: begin
				if (found_q) begin
					rsp_c.status    = lpht_pkg::STAT_OK;
					rsp_c.value_out = lpht_pkg::DATA_W'(hit_val_q);
				end
			end
			lpht_pkg::ACT_SET: begin
				if (skip_q) begin
					rsp_c.status = lpht_pkg::STAT_FULL;
				end else if (found_q) begin
					rsp_c.status = lpht_pkg::STAT_OK;
					fin_wr_c     = 1'b1;
				end else if (ins_ok_q) begin
					rsp_c.status  = lpht_pkg::STAT_OK;
					rsp_c.new_key = 1'b1;
					fin_wr_c      = 1'b1;
					fin_inc_c     = ins_empty_q;
				end else begin
					rsp_c.status = lpht_pkg::STAT_FULL;
				end
			end
			lpht_pkg::ACT_DEL: begin
				if (found_q) begin
					rsp_c.status = lpht_pkg::STAT_OK;
					fin_wr_c     = 1'b1;
					fin_kind_c   = lpht_pkg::KIND_TOMB;
					fin_val_c    = hit_val_q;
				end
			end
			default: begin
				rsp_c.status = lpht_pkg::STAT_MISS;
			end
		endcase

		// clearing pass owns the write port after reset
		we    = clr_q || ((state_q == lpht_pkg::S_FIN) && out_free && fin_wr_c);
		waddr = clr_q ? clr_idx_q : tgt_q;
		wdata = clr_q ? {lpht_pkg::KIND_EMPTY, {(KW + VALUE_BITS){1'b0}}}
		              : {fin_kind_c, req_q.key_id, fin_val_c};
	end

	assign cfg_ready = 1'b1;
	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

	// ---------------- control registers ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= lpht_pkg::S_IDLE;
			load_limit_q <= lpht_pkg::LIMIT_RST;
			used_q       <= '0;
			clr_q        <= 1'b1;
			clr_idx_q    <= '0;
			out_valid_q  <= 1'b0;
			rvalid_s1    <= 1'b0;
		end else begin
			state_q   <= state_d;
			rvalid_s1 <= rd_en;
			if (cfg_valid) begin
				load_limit_q <= cfg_data;
			end
			if (clr_q) begin
				clr_idx_q <= clr_idx_q + 1'b1;
				if (clr_idx_q == IDX_LAST) begin
					clr_q <= 1'b0;
				end
			end
			if ((state_q == lpht_pkg::S_FIN) && out_free && fin_inc_c) begin
				used_q <= used_q + 1'b1;
			end
			if ((state_q == lpht_pkg::S_FIN) && out_free) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// ---------------- datapath registers ----------------
	always_ff @(posedge clk) begin
		if (acc) begin
			req_q   <= in_data;
			skip_q  <= skip_c;
			found_q <= 1'b0;
			ins_ok_q <= 1'b0;
		end
		if ((state_q == lpht_pkg::S_IDLE && acc && hs_done) ||
		    (state_q == lpht_pkg::S_HASH && hs_done)) begin
			rd_idx_q <= hs_idx;
		end else if (rd_en) begin
			rd_idx_q <= (rd_idx_q == IDX_LAST) ? '0 : rd_idx_q + 1'b1;
		end
		idx_s1 <= rd_idx_q;

		if (state_q != lpht_pkg::S_PROBE) begin
			issued_q    <= '0;
			evald_q     <= '0;
			have_tomb_q <= 1'b0;
		end else begin
			if (rd_en) begin
				issued_q <= issued_q + 1'b1;
			end
			if (eval_c) begin
				evald_q <= evald_q + 1'b1;
			end
			if (tomb_new) begin
				have_tomb_q <= 1'b1;
				tomb_q      <= idx_s1;
			end
		end

		if (stop_c) begin
			found_q     <= is_hit;
			hit_val_q   <= r_val;
			ins_empty_q <= is_empty && !have_tomb_q;
			ins_ok_q    <= is_empty || have_tomb_q || tomb_new;
			if (is_hit) begin
				tgt_q <= idx_s1;
			end else if (have_tomb_q) begin
				tgt_q <= tomb_q;
			end else begin
				tgt_q <= idx_s1;
			end
		end

		if ((state_q == lpht_pkg::S_FIN) && out_free) begin
			out_data_q <= rsp_c;
		end
	end

endmodule

/* rtl/lpht_ram.sv */
module lpht_ram #(
	parameter int DEPTH = 256,
	parameter int WIDTH = 66
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

/* rtl/lpht_start.sv */
// Start slot = hash mod CAPACITY. Power of two: mask, same cycle.
// Otherwise a radix-4 restoring reduction, two hash bits per cycle.
module lpht_start #(
	parameter int CAPACITY = 256
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  lpht_pkg::hs_req_t           req,
	output logic                        done,
	output logic [$clog2(CAPACITY)-1:0] idx
);

	localparam int IW   = $clog2(CAPACITY);
	localparam bit POW2 = (CAPACITY & (CAPACITY - 1)) == 0;

	generate
		if (POW2) begin : g_mask
			assign done = req.start;
			assign idx  = req.hash[IW-1:0];
		end else begin : g_reduce
			localparam int RW = IW + 2;
			localparam int SW = $clog2(lpht_pkg::HASH_STEPS);
			localparam logic [RW-1:0] C1 = RW'(CAPACITY);
			localparam logic [RW-1:0] C2 = RW'(2 * CAPACITY);
			localparam logic [RW-1:0] C3 = RW'(3 * CAPACITY);
			localparam logic [SW-1:0] LAST = SW'(lpht_pkg::HASH_STEPS - 1);

			logic [lpht_pkg::HASH_W-1:0] h_q;
			logic [IW-1:0]               r_q;
			logic [SW-1:0]               cnt_q;
			logic                        busy_q;
			logic [RW-1:0]               t;
			logic [RW-1:0]               nr;

			always_comb begin
				t = {r_q, h_q[lpht_pkg::HASH_W-1 -: 2]};
				if (t >= C3) begin
					nr = t - C3;
				end else if (t >= C2) begin
					nr = t - C2;
				end else if (t >= C1) begin
					nr = t - C1;
				end else begin
					nr = t;
				end
			end

			assign done = busy_q && (cnt_q == LAST);
			assign idx  = nr[IW-1:0];

			always_ff @(posedge clk or negedge arst_n) begin
				if (!arst_n) begin
					busy_q <= 1'b0;
					cnt_q  <= '0;
				end else if (req.start) begin
					busy_q <= 1'b1;
					cnt_q  <= '0;
				end else if (busy_q) begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == LAST) begin
						busy_q <= 1'b0;
					end
				end
			end

			always_ff @(posedge clk) begin
				if (req.start) begin
					h_q <= req.hash;
					r_q <= '0;
				end else if (busy_q) begin
					h_q <= {h_q[lpht_pkg::HASH_W-3:0], 2'b00};
					r_q <= nr[IW-1:0];
				end
			end
		end
	endgenerate

endmodule

/* rtl/lpht_check.sv */
module lpht_check (
	input logic           clk,
	input logic           arst_n,
	input logic           in_valid,
	input logic           in_stall,
	input logic           out_valid,
	input logic           out_stall,
	input lpht_pkg::rsp_t out_data
);

	// outstanding items: one in the core plus one held at the output
	logic [1:0] pend_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q <= '0;
		end else begin
			pend_q <= pend_q + {1'b0, in_valid && !in_stall} - {1'b0, out_valid && !out_stall};
		end
	end

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(out_data))
		else $error("result changed while stalled");

	a_no_orphan: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> pend_q != 2'd0)
		else $error("result with no item outstanding");

	a_pend_bound: assert property (@(posedge clk) disable iff (!arst_n)
		pend_q == 2'd2 |-> in_stall)
		else $error("input taken with two items outstanding");

	a_new_key_ok: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (out_data.new_key || out_data.value_out != '0)
			|-> out_data.status == lpht_pkg::STAT_OK)
		else $error("new_key or value reported without success");

endmodule

bind linear_probe_hash_table lpht_check u_check (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_stall  (in_stall),
	.out_valid (out_valid),
	.out_stall (out_stall),
	.out_data  (out_data)
);

/* dv/tb_linear_probe_hash_table.sv */
module tb_linear_probe_hash_table;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int SLOTS    = 256;
	localparam int HOT_KEYS = 48;

	localparam logic [1:0] ACT_UNUSED = 2'd3;

	typedef struct {
		bit                           is_cfg;
		logic [lpht_pkg::LIMIT_W-1:0] limit;
		lpht_pkg::req_t               req;
		bit                           typed;
		lpht_pkg::rsp_t               want;
	} step_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	lpht_pkg::req_t in_data = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	lpht_pkg::rsp_t out_data;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [lpht_pkg::LIMIT_W-1:0] cfg_data = '0;

	// shadow copy of the slot table
	logic [lpht_pkg::KIND_W-1:0]  tbl_kind [SLOTS];
	logic [lpht_pkg::KEY_W-1:0]   tbl_key  [SLOTS];
	logic [lpht_pkg::DATA_W-1:0]  tbl_val  [SLOTS];
	int                           tbl_used = 0;
	logic [lpht_pkg::LIMIT_W-1:0] tbl_limit = lpht_pkg::LIMIT_RST;

	lpht_pkg::rsp_t rsp_due [$];
	int   bad_count = 0;
	int   send_idle = 38;
	int   recv_idle = 85;
	int   hold_left = 0;

	logic [lpht_pkg::KEY_W-1:0]  hot_key  [HOT_KEYS];
	logic [lpht_pkg::HASH_W-1:0] hot_hash [HOT_KEYS];

	step_t script [25];

	always #1 clk = ~clk;

	linear_probe_hash_table #(
		.CAPACITY   (SLOTS),
		.VALUE_BITS (lpht_pkg::DATA_W)
	) u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data)
	);

	// walk the probe chain; returns 1 on a key match
	function automatic bit probe_table(input logic [lpht_pkg::KEY_W-1:0] key,
			input logic [lpht_pkg::HASH_W-1:0] hash, output int hit, output int ins,
			output bit ins_ok);
		int idx;
		int n;
		int tomb;
		bit have_tomb;
		idx = int'(hash % SLOTS);
		have_tomb = 1'b0;
		tomb = 0;
		hit = 0;
		ins = 0;
		ins_ok = 1'b0;
		for (n = 0; n < SLOTS; n++) begin
			if (tbl_kind[idx] == lpht_pkg::KIND_EMPTY) begin
				ins = have_tomb ? tomb : idx;
				ins_ok = 1'b1;
				return 1'b0;
			end else if (tbl_kind[idx] == lpht_pkg::KIND_LIVE) begin
				if (tbl_key[idx] == key) begin
					hit = idx;
					return 1'b1;
				end
			end else if (!have_tomb) begin
				have_tomb = 1'b1;
				tomb = idx;
			end
			idx = (idx + 1) % SLOTS;
		end
		if (have_tomb) begin
			ins = tomb;
			ins_ok = 1'b1;
		end
		return 1'b0;
	endfunction

	function automatic lpht_pkg::rsp_t table_op(input lpht_pkg::req_t r);
		lpht_pkg::rsp_t res;
		int hit;
		int ins;
		bit ins_ok;
		res = '0;
		res.status = lpht_pkg::STAT_MISS;
		case (r.action)
			lpht_pkg::ACT_GET: begin
				if (probe_table(r.key_id, r.key_hash, hit, ins, ins_ok)) begin
					res.status = lpht_pkg::STAT_OK;
					res.value_out = tbl_val[hit];
				end
			end
			lpht_pkg::ACT_SET: begin
				// load check comes first, even for a key already present
				if (tbl_used + 1 > int'(tbl_limit)) begin
					res.status = lpht_pkg::STAT_FULL;
				end else if (probe_table(r.key_id, r.key_hash, hit, ins, ins_ok)) begin
					tbl_val[hit] = r.value_in;
					res.status = lpht_pkg::STAT_OK;
				end else if (ins_ok) begin
					if (tbl_kind[ins] == lpht_pkg::KIND_EMPTY)
						tbl_used++;
					tbl_kind[ins] = lpht_pkg::KIND_LIVE;
					tbl_key[ins] = r.key_id;
					tbl_val[ins] = r.value_in;
					res.status = lpht_pkg::STAT_OK;
					res.new_key = 1'b1;
				end else begin
					res.status = lpht_pkg::STAT_FULL;
				end
			end
			lpht_pkg::ACT_DEL: begin
				if (probe_table(r.key_id, r.key_hash, hit, ins, ins_ok)) begin
					tbl_kind[hit] = lpht_pkg::KIND_TOMB;
					res.status = lpht_pkg::STAT_OK;
				end
			end
			default: ;
		endcase
		return res;
	endfunction

	function automatic step_t op_row(input logic [1:0] act, input logic [31:0] key,
			input logic [31:0] hash, input logic [31:0] val);
		step_t s;
		s.is_cfg = 1'b0;
		s.limit = '0;
		s.req = '{action: act, key_id: key, key_hash: hash, value_in: val};
		s.typed = 1'b0;
		s.want = '0;
		return s;
	endfunction

	function automatic step_t fixed_row(input logic [1:0] act, input logic [31:0] key,
			input logic [31:0] hash, input logic [31:0] val, input logic [1:0] st,
			input logic nk, input logic [31:0] vo);
		step_t s;
		s = op_row(act, key, hash, val);
		s.typed = 1'b1;
		s.want = '{status: st, new_key: nk, value_out: vo};
		return s;
	endfunction

	function automatic step_t limit_row(input logic [lpht_pkg::LIMIT_W-1:0] lim);
		step_t s;
		s = op_row(lpht_pkg::ACT_GET, '0, '0, '0);
		s.is_cfg = 1'b1;
		s.limit = lim;
		return s;
	endfunction

	task automatic log_fail(input string msg);
		if (bad_count < 10)
			$display("%s", msg);
		bad_count++;
	endtask

	task automatic push_op(input lpht_pkg::req_t r, input bit typed,
			input lpht_pkg::rsp_t want);
		lpht_pkg::rsp_t model_rsp;
		while ($urandom_range(99) < send_idle) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		in_data <= r;
		do @(posedge clk); while (in_stall);
		model_rsp = table_op(r);
		rsp_due.push_back(typed ? want : model_rsp);
	endtask

	task automatic drain_results();
		in_valid <= 1'b0;
		do @(posedge clk); while (rsp_due.size() != 0);
	endtask

	task automatic set_load_limit(input logic [lpht_pkg::LIMIT_W-1:0] lim);
		drain_results();
		cfg_valid <= 1'b1;
		cfg_data <= lim;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		tbl_limit = lim;
	endtask

	// mostly traffic on a small set of colliding keys, plus strays
	task automatic random_ops(input int count);
		lpht_pkg::req_t r;
		int n;
		int i;
		int roll;
		int pick;
		for (n = 0; n < count; n++) begin
			i = $urandom_range(HOT_KEYS - 1);
			roll = $urandom_range(99);
			pick = $urandom_range(99);
			r.action = pick < 35 ? lpht_pkg::ACT_GET
				: (pick < 75 ? lpht_pkg::ACT_SET : lpht_pkg::ACT_DEL);
			r.key_id = hot_key[i];
			r.key_hash = hot_hash[i];
			r.value_in = $urandom();
			if (roll >= 92) begin
				r.key_id = $urandom();
				r.action = 2'($urandom_range(3));
				if (r.action == lpht_pkg::ACT_SET && roll < 97)
					r.action = lpht_pkg::ACT_GET;
				if (roll >= 97)
					r.key_hash = $urandom();
			end else if (roll >= 88) begin
				// known key under the wrong hash
				r.key_hash = hot_hash[$urandom_range(HOT_KEYS - 1)];
			end
			push_op(r, 1'b0, '0);
		end
	endtask

	initial begin : result_check
		lpht_pkg::rsp_t want;
		forever begin
			@(posedge clk);
			if (out_valid && !out_stall) begin
				if (rsp_due.size() == 0) begin
					log_fail($sformatf("unexpected result: status %0d new_key %0d value_out %h",
						out_data.status, out_data.new_key, out_data.value_out));
				end else begin
					want = rsp_due.pop_front();
					if (out_data.status !== want.status || out_data.new_key !== want.new_key
							|| out_data.value_out !== want.value_out)
						log_fail($sformatf({"result mismatch (exp/got): status %0d/%0d ",
							"new_key %0d/%0d value_out %h/%h"},
							want.status, out_data.status, want.new_key, out_data.new_key,
							want.value_out, out_data.value_out));
				end
			end
			if (hold_left != 0) begin
				hold_left <= hold_left - 1;
				out_stall <= 1'b1;
			end else begin
				out_stall <= ($urandom_range(99) < recv_idle);
			end
		end
	end

	initial begin : stimulus
		lpht_pkg::req_t r;
		int i;
		logic [7:0] base;
		for (i = 0; i < SLOTS; i++)
			tbl_kind[i] = lpht_pkg::KIND_EMPTY;
		for (i = 0; i < HOT_KEYS; i++) begin
			case ($urandom_range(3))
				0: base = 8'hFC;
				1: base = 8'h40;
				2: base = 8'h9A;
				default: base = 8'($urandom());
			endcase
			hot_key[i] = $urandom();
			hot_hash[i] = {24'($urandom()), 8'(base + 8'($urandom_range(5)))};
		end

		script = '{
			fixed_row(lpht_pkg::ACT_GET, 32'h0, 32'h0, 32'h0,
				lpht_pkg::STAT_MISS, 1'b0, 32'h0),
			fixed_row(ACT_UNUSED, 32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF,
				lpht_pkg::STAT_MISS, 1'b0, 32'h0),
			fixed_row(lpht_pkg::ACT_DEL, 32'h5, 32'h5, 32'h0,
				lpht_pkg::STAT_MISS, 1'b0, 32'h0),
			fixed_row(lpht_pkg::ACT_SET, 32'h0, 32'h0, 32'hFFFFFFFF,
				lpht_pkg::STAT_OK, 1'b1, 32'h0),
			fixed_row(lpht_pkg::ACT_GET, 32'h0, 32'h0, 32'h0,
				lpht_pkg::STAT_OK, 1'b0, 32'hFFFFFFFF),
			fixed_row(lpht_pkg::ACT_SET, 32'h0, 32'h0, 32'h0,
				lpht_pkg::STAT_OK, 1'b0, 32'h0),
			fixed_row(lpht_pkg::ACT_GET, 32'h0, 32'h0, 32'hAAAAAAAA,
				lpht_pkg::STAT_OK, 1'b0, 32'h0),
			// last slot, then a collision that wraps to the bottom
			op_row(lpht_pkg::ACT_SET, 32'hFFFFFFFF, 32'hFFFFFFFF, 32'h12345678),
			op_row(lpht_pkg::ACT_SET, 32'h1, 32'h000000FF, 32'hA5A5A5A5),
			op_row(lpht_pkg::ACT_GET, 32'h1, 32'h000000FF, 32'h0),
			op_row(lpht_pkg::ACT_DEL, 32'hFFFFFFFF, 32'hFFFFFFFF, 32'h0),
			op_row(lpht_pkg::ACT_GET, 32'h1, 32'h000000FF, 32'h0),
			op_row(lpht_pkg::ACT_GET, 32'hFFFFFFFF, 32'hFFFFFFFF, 32'h0),
			op_row(lpht_pkg::ACT_SET, 32'h2, 32'h123456FF, 32'h5A5A5A5A),
			op_row(lpht_pkg::ACT_GET, 32'h2, 32'h123456FF, 32'h0),
			op_row(lpht_pkg::ACT_DEL, 32'h1, 32'h000000FF, 32'h0),
			op_row(lpht_pkg::ACT_SET, 32'h1, 32'h000000FF, 32'h00000001),
			limit_row(9'd0),
			fixed_row(lpht_pkg::ACT_SET, 32'h7, 32'h7, 32'h7,
				lpht_pkg::STAT_FULL, 1'b0, 32'h0),
			op_row(lpht_pkg::ACT_GET, 32'h0, 32'h0, 32'h0),
			limit_row(9'd1),
			// present key, still refused by the load check
			fixed_row(lpht_pkg::ACT_SET, 32'h0, 32'h0, 32'h9,
				lpht_pkg::STAT_FULL, 1'b0, 32'h0),
			limit_row(9'd256),
			op_row(lpht_pkg::ACT_SET, 32'h80000000, 32'h80000000, 32'h80000000),
			op_row(lpht_pkg::ACT_GET, 32'h80000000, 32'h80000000, 32'h0)
		};

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;

		foreach (script[k]) begin
			if (script[k].is_cfg)
				set_load_limit(script[k].limit);
			else
				push_op(script[k].req, script[k].typed, script[k].want);
		end

		random_ops(250);
		// long receiver hold-off while the sender keeps offering
		hold_left <= 400;
		random_ops(450);

		send_idle = 85;
		recv_idle = 38;
		set_load_limit(9'(tbl_used + 6 > SLOTS ? SLOTS : tbl_used + 6));
		random_ops(600);

		send_idle = 0;
		recv_idle = 0;
		set_load_limit(9'd256);
		random_ops(300);
		drain_results();
		random_ops(300);

		// limit above capacity: fill every slot so probes run the whole table
		set_load_limit(9'd511);
		for (i = 0; i < 300; i++) begin
			r.action = lpht_pkg::ACT_SET;
			r.key_id = {8'hC3, 24'(i)};
			r.key_hash = $urandom();
			r.value_in = $urandom();
			push_op(r, 1'b0, '0);
		end
		random_ops(60);

		drain_results();
		repeat (20) @(posedge clk);
		if (bad_count == 0 && rsp_due.size() == 0)
			$display("** linear_probe_hash_table: PASSED **");
		else
			$display("** linear_probe_hash_table: FAILED **");
		$finish;
	end

	initial begin : watchdog
		#6ms;
		$display("timeout with %0d results outstanding", rsp_due.size());
		$display("** linear_probe_hash_table: FAILED **");
		$finish;
	end

endmodule
